// ===== design/tkl_pkg.sv =====
// Package: shared constants, payload types and controller/datapath interface structs.
`default_nettype none

package tkl_pkg;

    localparam int LIST_ENTRIES = 16;
    localparam int CNT_W        = $clog2(LIST_ENTRIES + 1);
    localparam int IDX_W        = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
    localparam int TAG_W        = 32;
    localparam int SIZE_W       = 64;
    localparam int RANK_W       = 5;

    localparam logic MODE_OFFER = 1'b0;
    localparam logic MODE_DUMP  = 1'b1;

    localparam logic [RANK_W-1:0] RANK_REJECT = RANK_W'(LIST_ENTRIES);

    typedef struct packed {
        logic              mode;
        logic [TAG_W-1:0]  entry_tag;
        logic [SIZE_W-1:0] entry_size;
    } t_in_item;

    typedef struct packed {
        logic              entry_valid;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  out_tag;
        logic [SIZE_W-1:0] out_size;
        logic              last;
    } t_out_item;

    // Controller -> datapath
    typedef struct packed {
        logic offer;       // insert candidate and load its result
        logic dump_first;  // load slot 0 (or the empty-list result)
        logic dump_next;   // load slot at the read index
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic count_le1;   // dump finishes with its first result
        logic idx_last;    // read index points at the last held slot
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/top_k_largest_tracker.sv =====
// Top level: ranked list of the largest (size, tag) pairs with offer and dump.
`default_nettype none

// Keeps up to 16 (size, tag) pairs sorted by descending size; on equal sizes
// the older entry stays ahead. On an offer (mode 0) all slots are compared
// against the candidate in parallel and the chain shifts at the edge that
// loads its result, so offers transfer back to back every cycle while the
// result register drains. Each offer gives one result: entry_valid and the
// rank it took, or rank 16 with entry_valid low when the size is zero or the
// list is full of entries no smaller. A dump (mode 1) streams one result per
// held entry, one per cycle while the output is not stalled, from the single
// read port of the list, marking the last; with more than one entry held, the
// input is held off until the last result of the dump is loaded. An empty
// list dumps one result with entry_valid low. The output register lets the
// next item transfer in the cycle the current result transfers out.
module top_k_largest_tracker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tkl_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tkl_pkg::t_out_item       o_out_data
);

    tkl_pkg::t_dp_cmd cmd;
    tkl_pkg::t_dp_sts sts;

    // Sequence handshakes and the dump walk.
    tkl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_data.mode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Hold the ranked list and build each result.
    tkl_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// ===== design/tkl_datapath.sv =====
// Datapath: ranked list cell chain, insertion logic, dump index and result register.
`default_nettype none

module tkl_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tkl_pkg::t_in_item   i_in_data,
    input  wire tkl_pkg::t_dp_cmd    i_cmd,
    output tkl_pkg::t_dp_sts         o_sts,
    output tkl_pkg::t_out_item       o_out_data
);

    logic [tkl_pkg::SIZE_W-1:0] r_size [tkl_pkg::LIST_ENTRIES];
    logic [tkl_pkg::TAG_W-1:0]  r_tag  [tkl_pkg::LIST_ENTRIES];
    logic [tkl_pkg::CNT_W-1:0]  r_count;
    logic [tkl_pkg::IDX_W-1:0]  r_idx;
    tkl_pkg::t_out_item         r_out;

    logic [tkl_pkg::LIST_ENTRIES-1:0] hit;
    logic [tkl_pkg::CNT_W-1:0]        rank;
    logic                             ins_ok;
    logic                             full;
    tkl_pkg::t_out_item               n_out;

    assign full = (r_count == tkl_pkg::CNT_W'(tkl_pkg::LIST_ENTRIES));

    // Slot i beats the candidate unless it is held and strictly smaller.
    always_comb begin
        for (int i = 0; i < tkl_pkg::LIST_ENTRIES; i++) begin
            hit[i] = (tkl_pkg::CNT_W'(i) < r_count) && (i_in_data.entry_size > r_size[i]);
        end
    end

    // First smaller slot wins; none means append at the fill count.
    always_comb begin
        rank = r_count;
        for (int i = tkl_pkg::LIST_ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                rank = tkl_pkg::CNT_W'(i);
            end
        end
    end

    assign ins_ok = (i_in_data.entry_size != '0) &&
                    (rank < tkl_pkg::CNT_W'(tkl_pkg::LIST_ENTRIES));

    // Shift lower entries down and drop the candidate into its rank.
    always_ff @(posedge i_clk) begin
        if (i_cmd.offer && ins_ok) begin
            for (int i = 0; i < tkl_pkg::LIST_ENTRIES; i++) begin
                if (tkl_pkg::CNT_W'(i) == rank) begin
                    r_size[i] <= i_in_data.entry_size;
                    r_tag[i]  <= i_in_data.entry_tag;
                end else if (i > 0 && tkl_pkg::CNT_W'(i) > rank) begin
                    r_size[i] <= r_size[i-1];
                    r_tag[i]  <= r_tag[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.offer && ins_ok && !full) begin
                r_count <= r_count + tkl_pkg::CNT_W'(1);
            end
            if (i_cmd.dump_first) begin
                r_idx <= tkl_pkg::IDX_W'(1);
            end else if (i_cmd.dump_next) begin
                r_idx <= r_idx + tkl_pkg::IDX_W'(1);
            end
        end
    end

    always_comb begin
        n_out = r_out;
        if (i_cmd.offer) begin
            n_out.entry_valid = ins_ok;
            n_out.rank        = ins_ok ? tkl_pkg::RANK_W'(rank) : tkl_pkg::RANK_REJECT;
            n_out.out_tag     = i_in_data.entry_tag;
            n_out.out_size    = i_in_data.entry_size;
            n_out.last        = 1'b1;
        end else if (i_cmd.dump_first) begin
            if (r_count == '0) begin
                n_out.entry_valid = 1'b0;
                n_out.out_tag     = '0;
                n_out.out_size    = '0;
            end else begin
                n_out.entry_valid = 1'b1;
                n_out.out_tag     = r_tag[0];
                n_out.out_size    = r_size[0];
            end
            n_out.rank = '0;
            n_out.last = o_sts.count_le1;
        end else if (i_cmd.dump_next) begin
            n_out.entry_valid = 1'b1;
            n_out.rank        = tkl_pkg::RANK_W'(r_idx);
            n_out.out_tag     = r_tag[r_idx];
            n_out.out_size    = r_size[r_idx];
            n_out.last        = o_sts.idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_sts.count_le1 = (r_count <= tkl_pkg::CNT_W'(1));
    assign o_sts.idx_last  = ((tkl_pkg::CNT_W'(r_idx) + tkl_pkg::CNT_W'(1)) == r_count);
    assign o_out_data      = r_out;

endmodule

`default_nettype wire

// ===== design/tkl_ctrl.sv =====
// Controller: input/output handshakes and the dump sequencer.
`default_nettype none

module tkl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_mode,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire tkl_pkg::t_dp_sts  i_sts,
    output tkl_pkg::t_dp_cmd       o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic can_load;

    assign can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = can_load;
                if (i_in_valid && can_load) begin
                    n_out_valid = 1'b1;
                    if (i_in_mode == tkl_pkg::MODE_OFFER) begin
                        o_cmd.offer = 1'b1;
                    end else begin
                        o_cmd.dump_first = 1'b1;
                        if (!i_sts.count_le1) begin
                            n_state = ST_DUMP;
                        end
                    end
                end
            end
            ST_DUMP: begin
                if (can_load) begin
                    n_out_valid     = 1'b1;
                    o_cmd.dump_next = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/tkl_checker.sv =====
// Checker: port-level assertions for the tracker, bound to the top level.
`default_nettype none

module tkl_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire tkl_pkg::t_out_item o_out_data
);

    // A pending result holds until transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // No new item while a result is stuck in the output register.
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while output stalled");

    // An invalid result is a rejection or the empty-dump marker.
    a_invalid_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.entry_valid |->
        (o_out_data.rank == tkl_pkg::RANK_REJECT) ||
        (o_out_data.rank == '0 && o_out_data.last))
        else $error("malformed invalid result");

    // Rejected offers always close their item.
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rank == tkl_pkg::RANK_REJECT |->
        o_out_data.last && !o_out_data.entry_valid)
        else $error("rejected result not last or marked valid");

endmodule

bind top_k_largest_tracker tkl_checker u_tkl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
